[hdl/pas_pkg.sv]
// ----------------------------------------------------------------------------
// Prefix autocomplete search package
// Shared constants, channel payloads and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pas_pkg;

   localparam int MAX_TERMS   = 64;
   localparam int TERM_BYTES  = 200;
   localparam int IDX_W       = 6;
   localparam int CNT_W       = 7;
   localparam int LEN_W       = 8;
   localparam int SIDX_W      = CNT_W + 1;
   localparam int BADDR_W     = $clog2(MAX_TERMS * TERM_BYTES);

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_TERM   = 2'd1;
   localparam logic [1:0] KIND_PREFIX = 2'd2;
   localparam logic [1:0] KIND_QUERY  = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         char_byte;
      logic signed [63:0] term_weight_in;
      logic               term_end;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   term_index;
      logic signed [63:0] match_weight;
      logic [CNT_W-1:0]   match_count;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]   len_addr;
      logic [BADDR_W-1:0] byte_addr;
      logic [LEN_W-1:0]   pfx_addr;
      logic [IDX_W-1:0]   wt_addr;
      logic               prefix_clear;
      logic               taken_clear;
      logic               best_clear;
      logic               best_check;
      logic [IDX_W-1:0]   check_idx;
      logic               emit;
      logic               emit_found;
      logic [CNT_W-1:0]   emit_count;
      logic               emit_last;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]   term_count;
      logic [LEN_W-1:0]   prefix_len;
      logic [LEN_W-1:0]   term_len;
      logic [7:0]         term_byte;
      logic [7:0]         pfx_byte;
      logic               rsp_busy;
   } sts_type;

endpackage

[hdl/prefix_autocomplete_search.sv]
// Clear, term and prefix beats are taken one per cycle while no query is running.
// A query runs two binary searches of up to log2(terms) + 1 probes each; a probe
// reads the middle term and compares it with the prefix byte by byte.
// The sort then scans the weights of all n matches before each result beat,
// and waits while the result is stalled.
// Reset empties the term table and the prefix; memory contents stay undefined.
// ----------------------------------------------------------------------------
// Prefix autocomplete search
// Loads sorted weighted terms, finds the range matching a query prefix and
// returns the matches heaviest first.
// ----------------------------------------------------------------------------
module prefix_autocomplete_search import pas_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;
   logic    req_fire;

   assign req_fire = req_valid && !req_stall;

   pas_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   pas_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/pas_datapath.sv]
// ----------------------------------------------------------------------------
// Prefix autocomplete datapath
// Term, length, weight and prefix memories, load counters, best-weight
// selection and the result register.
// ----------------------------------------------------------------------------
module pas_datapath import pas_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [7:0]         term_mem [MAX_TERMS*TERM_BYTES];
   logic [LEN_W-1:0]   len_mem  [MAX_TERMS];
   logic [63:0]        wt_mem   [MAX_TERMS];
   logic [7:0]         pfx_mem  [TERM_BYTES];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]   build_ff, build_in;
   logic [LEN_W-1:0]   plen_ff, plen_in;
   logic [LEN_W-1:0]   len_q_ff;
   logic [7:0]         byte_q_ff, pfx_q_ff;
   logic signed [63:0] wt_q_ff;
   logic [MAX_TERMS-1:0] taken_ff;
   logic               best_valid_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic signed [63:0] best_w_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               term_wr, byte_wr, end_wr, pfx_wr;
   logic [LEN_W-1:0]   build_next;
   logic [BADDR_W-1:0] wr_addr;
   logic [IDX_W-1:0]   slot;
   logic               better;

   assign slot       = count_ff[IDX_W-1:0];
   assign term_wr    = req_fire && req_data.kind == KIND_TERM
                       && count_ff < CNT_W'(MAX_TERMS);
   assign byte_wr    = term_wr && build_ff < LEN_W'(TERM_BYTES);
   assign build_next = byte_wr ? build_ff + 1'b1 : build_ff;
   assign end_wr     = term_wr && req_data.term_end;
   assign pfx_wr     = req_fire && req_data.kind == KIND_PREFIX
                       && plen_ff < LEN_W'(TERM_BYTES);
   assign wr_addr    = BADDR_W'(slot) * BADDR_W'(TERM_BYTES) + BADDR_W'(build_ff);

   always_comb begin
      count_in = count_ff;
      build_in = build_ff;
      plen_in  = plen_ff;
      if (req_fire && req_data.kind == KIND_CLEAR) begin
         count_in = '0;
         build_in = '0;
      end
      if (term_wr) begin
         build_in = end_wr ? '0 : build_next;
         if (end_wr) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (pfx_wr) begin
         plen_in = plen_ff + 1'b1;
      end
      if (cmd.prefix_clear) begin
         plen_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         build_ff <= '0;
         plen_ff  <= '0;
      end else begin
         count_ff <= count_in;
         build_ff <= build_in;
         plen_ff  <= plen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_wr) begin
         term_mem[wr_addr] <= req_data.char_byte;
      end
      byte_q_ff <= term_mem[cmd.byte_addr];
   end

   always_ff @(posedge clock) begin
      if (end_wr) begin
         len_mem[slot] <= build_next;
      end
      len_q_ff <= len_mem[cmd.len_addr];
   end

   always_ff @(posedge clock) begin
      if (end_wr) begin
         wt_mem[slot] <= req_data.term_weight_in;
      end
      wt_q_ff <= wt_mem[cmd.wt_addr];
   end

   always_ff @(posedge clock) begin
      if (pfx_wr) begin
         pfx_mem[plen_ff] <= req_data.char_byte;
      end
      pfx_q_ff <= pfx_mem[cmd.pfx_addr];
   end

   assign better = !taken_ff[cmd.check_idx] && (!best_valid_ff || wt_q_ff > best_w_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff      <= '0;
         best_valid_ff <= 1'b0;
      end else begin
         if (cmd.taken_clear) begin
            taken_ff <= '0;
         end else if (cmd.emit && cmd.emit_found) begin
            taken_ff[best_idx_ff] <= 1'b1;
         end
         if (cmd.best_clear) begin
            best_valid_ff <= 1'b0;
         end else if (cmd.best_check && better) begin
            best_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.best_check && better) begin
         best_idx_ff <= cmd.check_idx;
         best_w_ff   <= wt_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.found        <= cmd.emit_found;
         rsp_ff.term_index   <= cmd.emit_found ? best_idx_ff : '0;
         rsp_ff.match_weight <= cmd.emit_found ? best_w_ff : '0;
         rsp_ff.match_count  <= cmd.emit_count;
         rsp_ff.last_result  <= cmd.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sts.term_count = count_ff;
   assign sts.prefix_len = plen_ff;
   assign sts.term_len   = len_q_ff;
   assign sts.term_byte  = byte_q_ff;
   assign sts.pfx_byte   = pfx_q_ff;
   assign sts.rsp_busy   = rsp_valid_ff;

endmodule

[hdl/pas_controller.sv]
// ----------------------------------------------------------------------------
// Prefix autocomplete controller
// Runs the two binary searches for the prefix range and the repeated
// heaviest-term scans that order the matches.
// ----------------------------------------------------------------------------
module pas_controller import pas_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_kind,
   output logic       req_stall,
   output cmd_type    cmd,
   input  sts_type    sts
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_INIT = 9'b000000010,
      ST_MID  = 9'b000000100,
      ST_RD   = 9'b000001000,
      ST_CMP  = 9'b000010000,
      ST_DONE = 9'b000100000,
      ST_SORT = 9'b001000000,
      ST_SRD  = 9'b010000000,
      ST_SCMP = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      ORD_LT,
      ORD_EQ,
      ORD_GT
   } ord_type;

   state_type state_ff, state_in;
   logic emit_st_ff, emit_st_in;
   logic lowest_ff, lowest_in, miss_ff, miss_in;
   logic signed [SIDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in, found_ff, found_in;
   logic signed [SIDX_W-1:0] first_ff, first_in, nlo, nhi;
   logic [IDX_W-1:0] mid_ff, mid_in, j_ff, j_in, last_ff, last_in, mid_calc;
   logic [LEN_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] k_ff, k_in, n_ff, n_in;
   logic [SIDX_W:0]  mid_sum;
   logic decided;
   ord_type ord;

   assign mid_sum  = (SIDX_W+1)'(lo_ff) + (SIDX_W+1)'(hi_ff);
   assign mid_calc = mid_sum[IDX_W:1];

   always_comb begin
      decided = 1'b0;
      ord     = ORD_EQ;
      if (state_ff == ST_RD && i_ff == sts.prefix_len) begin
         decided = 1'b1;
      end else if (state_ff == ST_CMP) begin
         if (i_ff >= sts.term_len) begin
            decided = 1'b1;
            ord     = ORD_GT;
         end else if (sts.pfx_byte < sts.term_byte) begin
            decided = 1'b1;
            ord     = ORD_LT;
         end else if (sts.pfx_byte > sts.term_byte) begin
            decided = 1'b1;
            ord     = ORD_GT;
         end
      end
      nlo = lo_ff;
      nhi = hi_ff;
      if (ord == ORD_GT || (ord == ORD_EQ && !lowest_ff)) begin
         nlo = SIDX_W'(mid_ff) + 1'b1;
      end else begin
         nhi = SIDX_W'(mid_ff) - 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      emit_st_in = 1'b0;
      lowest_in  = lowest_ff;
      miss_in    = miss_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      found_in   = found_ff;
      first_in   = first_ff;
      mid_in     = mid_ff;
      j_in       = j_ff;
      last_in    = last_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      cmd              = '0;
      cmd.len_addr     = (state_ff == ST_MID) ? mid_calc : mid_ff;
      cmd.byte_addr    = BADDR_W'(mid_ff) * BADDR_W'(TERM_BYTES) + BADDR_W'(i_ff);
      cmd.pfx_addr     = i_ff;
      cmd.wt_addr      = j_ff;
      cmd.check_idx    = j_ff;
      cmd.emit_found   = !miss_ff;
      cmd.emit_count   = miss_ff ? '0 : n_ff;
      cmd.emit_last    = miss_ff || (k_ff == n_ff - 1'b1);

      if (emit_st_ff) begin
         emit_st_in = 1'b1;
         if (!sts.rsp_busy) begin
            cmd.emit   = 1'b1;
            emit_st_in = 1'b0;
            if (cmd.emit_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.best_clear = 1'b1;
               k_in     = k_ff + 1'b1;
               j_in     = first_ff[IDX_W-1:0];
               state_in = ST_SRD;
            end
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_kind == KIND_QUERY) begin
                  lowest_in = 1'b1;
                  state_in  = ST_INIT;
               end
            end
            ST_INIT: begin
               lo_in    = '0;
               hi_in    = SIDX_W'(sts.term_count) - 1'b1;
               found_in = '1;
               state_in = (sts.term_count == '0) ? ST_DONE : ST_MID;
            end
            ST_MID: begin
               mid_in   = mid_calc;
               i_in     = '0;
               state_in = ST_RD;
            end
            ST_RD, ST_CMP: begin
               if (decided) begin
                  lo_in = nlo;
                  hi_in = nhi;
                  if (ord == ORD_EQ) begin
                     found_in = SIDX_W'(mid_ff);
                  end
                  state_in = (nlo <= nhi) ? ST_MID : ST_DONE;
               end else if (state_ff == ST_RD) begin
                  state_in = ST_CMP;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
            ST_DONE: begin
               if (lowest_ff) begin
                  first_in  = found_ff;
                  lowest_in = 1'b0;
                  state_in  = ST_INIT;
               end else begin
                  cmd.prefix_clear = 1'b1;
                  last_in = found_ff[IDX_W-1:0];
                  n_in    = CNT_W'(found_ff - first_ff + 1'b1);
                  if (first_ff < 0 || found_ff < first_ff) begin
                     miss_in    = 1'b1;
                     emit_st_in = 1'b1;
                  end else begin
                     miss_in  = 1'b0;
                     state_in = ST_SORT;
                  end
               end
            end
            ST_SORT: begin
               cmd.taken_clear = 1'b1;
               cmd.best_clear  = 1'b1;
               k_in     = '0;
               j_in     = first_ff[IDX_W-1:0];
               state_in = ST_SRD;
            end
            ST_SRD: begin
               state_in = ST_SCMP;
            end
            ST_SCMP: begin
               cmd.best_check = 1'b1;
               if (j_ff == last_ff) begin
                  emit_st_in = 1'b1;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_SRD;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || emit_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         emit_st_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         emit_st_ff <= emit_st_in;
      end
   end

   always_ff @(posedge clock) begin
      lowest_ff <= lowest_in;
      miss_ff   <= miss_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      found_ff  <= found_in;
      first_ff  <= first_in;
      mid_ff    <= mid_in;
      j_ff      <= j_in;
      last_ff   <= last_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
      n_ff      <= n_in;
   end

endmodule
